/* src/rgbmf_pkg.sv */
// Shared constants and types of the RGB median window filter.
`default_nettype none
package rgbmf_pkg;

    localparam int CHAN_W     = 8;
    localparam int PIX_W      = 3 * CHAN_W;
    localparam int MASK_W     = 3;
    localparam int FRAME_W    = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MASK_SIZE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd2;

    localparam logic [MASK_W-1:0]  MASK_RST   = 3'd3;
    localparam logic [FRAME_W-1:0] WIDTH_RST  = 11'd640;
    localparam logic [FRAME_W-1:0] HEIGHT_RST = 11'd480;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_pix;

endpackage
`default_nettype wire

/* src/rgbmf_in_if.sv */
// Input pixel channel: valid/ready handshake with RGB payload and flush flag.
`default_nettype none
interface rgbmf_in_if;
    logic                        valid;
    logic                        ready;
    logic [rgbmf_pkg::CHAN_W-1:0] red_in;
    logic [rgbmf_pkg::CHAN_W-1:0] green_in;
    logic [rgbmf_pkg::CHAN_W-1:0] blue_in;
    logic                        is_flush;

    modport source (output valid, red_in, green_in, blue_in, is_flush, input ready);
    modport sink   (input valid, red_in, green_in, blue_in, is_flush, output ready);
endinterface
`default_nettype wire

/* src/rgbmf_out_if.sv */
// Output pixel channel: valid/ready handshake with RGB payload and frame end flag.
`default_nettype none
interface rgbmf_out_if;
    logic                        valid;
    logic                        ready;
    logic [rgbmf_pkg::CHAN_W-1:0] red_out;
    logic [rgbmf_pkg::CHAN_W-1:0] green_out;
    logic [rgbmf_pkg::CHAN_W-1:0] blue_out;
    logic                        frame_last;

    modport source (output valid, red_out, green_out, blue_out, frame_last, input ready);
    modport sink   (input valid, red_out, green_out, blue_out, frame_last, output ready);
endinterface
`default_nettype wire

/* src/rgb_median_window_filter_core.sv */
// RGB median window filter: line store, window registers and pipelined median.
//
// Usage: pixels of a frame enter in raster order on i_pix, one transfer per
// pixel; after the last pixel, flush transfers (is_flush = 1) push out the
// remaining results. Each pixel leaves on o_pix replaced by the per-channel
// median of its square window (side 2*rad+1, rad = mask_size/2 limited to
// MAX_MASK/2); pixels whose window leaves the frame pass unchanged. frame_last
// marks the final pixel of the frame; then the frame position restarts.
// A result is due once rad*width+rad further items are taken; it passes through
// stages B, C, D and the output register to o_pix. One item a cycle is taken:
// the line store does one read at the input's column and one write back per
// cycle, and the median unit is a two-stage compare/count/select pipeline.
// When the receiver stalls, the output register holds and i_pix.ready drops;
// with o_pix.ready high the block takes a pixel every cycle.
// Configuration writes on i_cfg_* are to be made only while idle (the block does
// not enforce this) and restart the frame. Reset clears positions and the
// pipeline and restores register defaults; the line and delay stores are not
// cleared (no clearing pass), since only entries written in the current frame are ever used.
`default_nettype none
module rgb_median_window_filter_core #(
    parameter int MAX_MASK  = 5,
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [rgbmf_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [rgbmf_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    rgbmf_in_if.sink                                 i_pix,
    rgbmf_out_if.source                              o_pix
);

    localparam int RAD_MAX = MAX_MASK / 2;
    localparam int SIDE    = 2 * RAD_MAX + 1;
    localparam int CELLS   = SIDE * SIDE;
    localparam int HROWS   = SIDE - 1;
    localparam int CW      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int MAX_LAG = RAD_MAX * MAX_WIDTH + RAD_MAX;
    localparam int LW      = $clog2(MAX_LAG + 1);
    localparam int DW      = LW;
    localparam int DDEPTH  = 1 << DW;
    localparam int RW      = $clog2(RAD_MAX + 1);
    localparam int CNTW    = $clog2(CELLS + 1);
    localparam int PW      = rgbmf_pkg::PIX_W;
    localparam int FW      = rgbmf_pkg::FRAME_W;
    localparam int LINE_W  = HROWS * PW;
    localparam int XW      = ((CW + 1 > FW) ? CW + 1 : FW) + 1;

    // ---------------------------------------------------------------- config
    logic [rgbmf_pkg::MASK_W-1:0] r_mask;
    logic [FW-1:0]                r_fw;
    logic [FW-1:0]                r_fh;
    logic                         cfg_restart;

    assign cfg_restart = i_cfg_we && (i_cfg_idx == rgbmf_pkg::CFG_MASK_SIZE ||
                                      i_cfg_idx == rgbmf_pkg::CFG_FRAME_WIDTH ||
                                      i_cfg_idx == rgbmf_pkg::CFG_FRAME_HEIGHT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= rgbmf_pkg::MASK_RST;
            r_fw   <= rgbmf_pkg::WIDTH_RST;
            r_fh   <= rgbmf_pkg::HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rgbmf_pkg::CFG_MASK_SIZE:    r_mask <= i_cfg_data[rgbmf_pkg::MASK_W-1:0];
                rgbmf_pkg::CFG_FRAME_WIDTH:  r_fw   <= i_cfg_data[FW-1:0];
                rgbmf_pkg::CFG_FRAME_HEIGHT: r_fh   <= i_cfg_data[FW-1:0];
                default: ;
            endcase
        end
    end

    // effective geometry
    logic [1:0]      mask_half;
    logic [RW-1:0]   rad;
    logic [CW:0]     w_eff;
    logic [CW-1:0]   wm1;
    logic [FW-1:0]   h_eff;
    logic [FW-1:0]   hm1;
    logic [LW-1:0]   lag;
    logic [CNTW-1:0] med_k;

    assign mask_half = r_mask[2:1];

    always_comb begin
        if (32'(mask_half) > RAD_MAX) rad = RW'(RAD_MAX);
        else                          rad = RW'(mask_half);
        if (r_fw == '0)                  w_eff = (CW+1)'(1);
        else if (32'(r_fw) > MAX_WIDTH)  w_eff = (CW+1)'(MAX_WIDTH);
        else                             w_eff = (CW+1)'(r_fw);
        h_eff = (r_fh == '0) ? FW'(1) : r_fh;
    end

    assign wm1   = CW'(w_eff - (CW+1)'(1));
    assign hm1   = h_eff - FW'(1);
    assign lag   = LW'(rad) * LW'(w_eff) + LW'(rad);
    assign med_k = CNTW'(2) * CNTW'(rad) * (CNTW'(rad) + CNTW'(1));

    // ------------------------------------------------------ stream positions
    logic [CW-1:0] r_in_col, n_in_col;
    logic [FW-1:0] r_in_row, n_in_row;
    logic [CW-1:0] r_q_col,  n_q_col;
    logic [FW-1:0] r_q_row,  n_q_row;
    logic [LW-1:0] r_cnt,    n_cnt;
    logic [DW-1:0] r_wp,     n_wp;

    logic          adv, accept, pix_phase, consume, wr, produce, interior, is_last;
    logic [DW-1:0] rd_addr;
    rgbmf_pkg::t_pix in_pix;

    // the whole pipeline moves unless a finished result is stalled
    assign adv         = !o_pix.valid || o_pix.ready;
    assign i_pix.ready = adv;
    assign accept      = i_pix.valid && adv;
    assign pix_phase   = r_in_row < h_eff;
    // drop a flush during the pixel phase; a pixel in the drain phase acts as a flush
    assign consume     = accept && !(pix_phase && i_pix.is_flush);
    assign wr          = consume && pix_phase;
    assign produce     = consume && (r_cnt == lag);
    assign is_last     = (r_q_row == hm1) && (r_q_col == wm1);
    assign rd_addr     = r_wp - DW'(lag);
    assign in_pix      = '{red: i_pix.red_in, green: i_pix.green_in, blue: i_pix.blue_in};

    assign interior = (rad != '0) &&
                      (XW'(r_q_row) >= XW'(rad)) &&
                      (XW'(r_q_row) + XW'(rad) < XW'(h_eff)) &&
                      (XW'(r_q_col) >= XW'(rad)) &&
                      (XW'(r_q_col) + XW'(rad) < XW'(w_eff));

    always_comb begin
        n_in_col = r_in_col;
        n_in_row = r_in_row;
        n_q_col  = r_q_col;
        n_q_row  = r_q_row;
        n_cnt    = r_cnt;
        n_wp     = r_wp;
        if (wr) begin
            if (r_in_col == wm1) begin
                n_in_col = '0;
                n_in_row = r_in_row + FW'(1);
            end else begin
                n_in_col = r_in_col + CW'(1);
            end
        end
        if (consume) begin
            n_wp = r_wp + DW'(1);
            if (r_cnt != lag) n_cnt = r_cnt + LW'(1);
        end
        if (produce) begin
            if (r_q_col == wm1) begin
                n_q_col = '0;
                n_q_row = r_q_row + FW'(1);
            end else begin
                n_q_col = r_q_col + CW'(1);
            end
        end
        // frame end or a register write restarts the frame
        if ((produce && is_last) || cfg_restart) begin
            n_in_col = '0;
            n_in_row = '0;
            n_q_col  = '0;
            n_q_row  = '0;
            n_cnt    = '0;
            n_wp     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col <= '0;
            r_in_row <= '0;
            r_q_col  <= '0;
            r_q_row  <= '0;
            r_cnt    <= '0;
            r_wp     <= '0;
        end else begin
            r_in_col <= n_in_col;
            r_in_row <= n_in_row;
            r_q_col  <= n_q_col;
            r_q_row  <= n_q_row;
            r_cnt    <= n_cnt;
            r_wp     <= n_wp;
        end
    end

    // ------------------------------------------------------------- memories
    // line store: per column, the pixels of the previous HROWS rows
    logic [LINE_W-1:0] line_mem [MAX_WIDTH];
    logic [LINE_W-1:0] r_line_rd;
    logic [LINE_W-1:0] line_old;
    logic [LINE_W-1:0] line_wdata;
    logic              line_we;

    // delay store: raw pixels, read back lag items later for pass-through
    logic [PW-1:0]     dly_mem [DDEPTH];
    logic [PW-1:0]     r_dly_rd;

    // stage B: line store data arrives
    logic              r_b_v, r_b_wr, r_b_prod, r_b_int, r_b_last, r_b_byp;
    rgbmf_pkg::t_pix   r_b_pix;
    logic [CW-1:0]     r_b_col;
    logic              r_fwd_hit;
    logic [LINE_W-1:0] r_fwd_data;

    assign line_we    = adv && r_b_v && r_b_wr;
    assign line_old   = r_fwd_hit ? r_fwd_data : r_line_rd;
    assign line_wdata = {line_old[LINE_W-PW-1:0], r_b_pix};

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_line_rd <= line_mem[r_in_col];
        end
        if (line_we) begin
            line_mem[r_b_col] <= line_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (consume) begin
            r_dly_rd <= dly_mem[rd_addr];
        end
        if (wr) begin
            dly_mem[r_wp] <= in_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v     <= 1'b0;
            r_fwd_hit <= 1'b0;
        end else if (adv) begin
            r_b_v      <= consume;
            r_b_wr     <= wr;
            r_b_prod   <= produce;
            r_b_int    <= interior;
            r_b_last   <= is_last;
            r_b_byp    <= (lag == '0);
            r_b_pix    <= in_pix;
            r_b_col    <= r_in_col;
            // same column written back as the new item reads it: forward
            r_fwd_hit  <= wr && r_b_v && r_b_wr && (r_b_col == r_in_col);
            r_fwd_data <= line_wdata;
        end
    end

    // ------------------------------------------------------------- window
    rgbmf_pkg::t_pix colvec [SIDE];
    rgbmf_pkg::t_pix r_win  [SIDE][SIDE];

    always_comb begin
        colvec[0] = r_b_pix;
        for (int r = 1; r < SIDE; r++) begin
            colvec[r] = rgbmf_pkg::t_pix'(line_old[PW*(r-1) +: PW]);
        end
    end

    // column 0 is the newest, row 0 the current row
    always_ff @(posedge i_clk) begin
        if (line_we) begin
            for (int c = SIDE - 1; c > 0; c--) begin
                r_win[c] <= r_win[c-1];
            end
            for (int r = 0; r < SIDE; r++) begin
                r_win[0][r] <= colvec[r];
            end
        end
    end

    // stage C: window holds this item's neighborhood
    logic            r_c_v, r_c_int, r_c_last;
    rgbmf_pkg::t_pix r_c_pass;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else if (adv) begin
            r_c_v    <= r_b_v && r_b_prod;
            r_c_int  <= r_b_int;
            r_c_last <= r_b_last;
            r_c_pass <= r_b_byp ? r_b_pix : rgbmf_pkg::t_pix'(r_dly_rd);
        end
    end

    // rank every cell: it is the median if k cells or fewer lie below it
    // and more than k lie at or below it
    logic [CELLS-1:0]                 used;
    logic [rgbmf_pkg::CHAN_W-1:0]     cval [3][CELLS];
    logic [CELLS-1:0]                 c_sel [3];
    logic [CELLS-1:0]                 lt_v, le_v;

    always_comb begin
        for (int c = 0; c < SIDE; c++) begin
            for (int r = 0; r < SIDE; r++) begin
                used[c*SIDE+r]    = (c <= 2 * int'(rad)) && (r <= 2 * int'(rad));
                cval[0][c*SIDE+r] = r_win[c][r].red;
                cval[1][c*SIDE+r] = r_win[c][r].green;
                cval[2][c*SIDE+r] = r_win[c][r].blue;
            end
        end
    end

    always_comb begin
        lt_v = '0;
        le_v = '0;
        for (int ch = 0; ch < 3; ch++) begin
            for (int i = 0; i < CELLS; i++) begin
                for (int j = 0; j < CELLS; j++) begin
                    lt_v[j] = used[j] && (cval[ch][j] <  cval[ch][i]);
                    le_v[j] = used[j] && (cval[ch][j] <= cval[ch][i]);
                end
                c_sel[ch][i] = used[i] && (CNTW'($countones(lt_v)) <= med_k) &&
                               (CNTW'($countones(le_v)) > med_k);
            end
        end
    end

    // stage D: selection masks and cell values
    logic                         r_d_v, r_d_int, r_d_last;
    rgbmf_pkg::t_pix              r_d_pass;
    logic [CELLS-1:0]             r_d_sel [3];
    logic [rgbmf_pkg::CHAN_W-1:0] r_d_val [3][CELLS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= 1'b0;
        end else if (adv) begin
            r_d_v    <= r_c_v;
            r_d_int  <= r_c_int;
            r_d_last <= r_c_last;
            r_d_pass <= r_c_pass;
            r_d_sel  <= c_sel;
            r_d_val  <= cval;
        end
    end

    // equal values may share the median rank, so OR the selected cells
    logic [rgbmf_pkg::CHAN_W-1:0] med [3];

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            med[ch] = '0;
            for (int i = 0; i < CELLS; i++) begin
                if (r_d_sel[ch][i]) med[ch] = med[ch] | r_d_val[ch][i];
            end
        end
    end

    // output register
    logic            r_out_v, r_out_last;
    rgbmf_pkg::t_pix r_out_pix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (adv) begin
            r_out_v    <= r_d_v;
            r_out_last <= r_d_last;
            r_out_pix  <= r_d_int ? '{red: med[0], green: med[1], blue: med[2]} : r_d_pass;
        end
    end

    assign o_pix.valid      = r_out_v;
    assign o_pix.red_out    = r_out_pix.red;
    assign o_pix.green_out  = r_out_pix.green;
    assign o_pix.blue_out   = r_out_pix.blue;
    assign o_pix.frame_last = r_out_last;

    // ----------------------------------------------------------- assertions
    a_fwd_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd_hit |-> (r_b_v && r_b_wr))
        else $error("line store forward without a write item in stage B");

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (produce && is_last) |=> (r_q_row == '0 && r_q_col == '0 && r_cnt == '0))
        else $error("frame position not restarted after last pixel");

    a_dly_no_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr && lag != '0) |-> (rd_addr != r_wp))
        else $error("delay store read and write hit the same entry");

    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pix.valid && !o_pix.ready) |-> !i_pix.ready)
        else $error("input taken while output stalled");

endmodule
`default_nettype wire
